### rtl/dcc_packet_bit_transmitter_defines.svh
// Assertion helpers used by dcc_back.
`ifndef DCC_PACKET_BIT_TRANSMITTER_DEFINES_SVH
`define DCC_PACKET_BIT_TRANSMITTER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DCC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DCC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/dcc_pkg.sv
package dcc_pkg;

  localparam int DEF_MAX_PACKET_BYTES = 8;
  localparam int DEF_TICK_COUNT_BITS  = 16;

  localparam int PRE_W      = 5;
  localparam int HALF_W     = 16;
  localparam int BYTE_W     = 8;
  localparam int INDEX_W    = 3;
  localparam int COUNT_W    = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_PREAMBLE_BITS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ONE_HALF_TICKS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_HALF_TICKS = 2'd2;

  localparam logic [PRE_W-1:0]  RST_PREAMBLE_BITS   = 5'd16;
  localparam logic [HALF_W-1:0] RST_ONE_HALF_TICKS  = 16'd58;
  localparam logic [HALF_W-1:0] RST_ZERO_HALF_TICKS = 16'd100;

  localparam logic [BYTE_W-1:0] IDLE_FILL_BYTE = 8'hFF;
  localparam int                IDLE_COUNT     = 3;

  typedef struct packed {
    logic                is_load;
    logic                idx_ok;
    logic [BYTE_W-1:0]   byte_value;
    logic [INDEX_W-1:0]  byte_index;
    logic                packet_done;
    logic [COUNT_W-1:0]  byte_count;
  } dcc_cmd_t;

endpackage

### rtl/dcc_in_if.sv
interface dcc_in_if import dcc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               func;
  logic [BYTE_W-1:0]  byte_value;
  logic [INDEX_W-1:0] byte_index;
  logic               packet_done;
  logic [COUNT_W-1:0] byte_count;

  modport source (
    output valid, func, byte_value, byte_index, packet_done, byte_count,
    input  ready
  );
  modport sink (
    input  valid, func, byte_value, byte_index, packet_done, byte_count,
    output ready
  );
endinterface

### rtl/dcc_out_if.sv
interface dcc_out_if ();
  logic valid;
  logic ready;
  logic line_level;
  logic bit_start;
  logic packet_start;

  modport source (output valid, line_level, bit_start, packet_start, input ready);
  modport sink (input valid, line_level, bit_start, packet_start, output ready);
endinterface

### rtl/dcc_cfg_if.sv
interface dcc_cfg_if import dcc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### rtl/dcc_front.sv
module dcc_front import dcc_pkg::*; #(
  parameter int MAX_PACKET_BYTES = DEF_MAX_PACKET_BYTES
) (
  input  logic      clk,
  input  logic      rst_n,
  dcc_in_if.sink    in_ch,
  output logic      q_valid,
  output dcc_cmd_t  q_cmd,
  input  logic      q_pop
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  dcc_cmd_t         queue_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic             push;
  dcc_cmd_t         cmd;

  assign in_ch.ready = (fill_r != CNT_W'(QUEUE_DEPTH));
  assign push        = in_ch.valid && in_ch.ready;

  always_comb begin
    cmd.is_load     = in_ch.func;
    cmd.idx_ok      = (32'(in_ch.byte_index) < MAX_PACKET_BYTES);
    cmd.byte_value  = in_ch.byte_value;
    cmd.byte_index  = in_ch.byte_index;
    cmd.packet_done = in_ch.packet_done;
    cmd.byte_count  = in_ch.byte_count;
  end

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = q_pop ? rd_ptr_r + PTR_W'(1) : rd_ptr_r;
    fill_nxt   = fill_r;
    if (push && !q_pop) begin
      fill_nxt = fill_r + CNT_W'(1);
    end else if (!push && q_pop) begin
      fill_nxt = fill_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue_r[wr_ptr_r] <= cmd;
    end
  end

  assign q_valid = (fill_r != '0);
  assign q_cmd   = queue_r[rd_ptr_r];

endmodule

### rtl/dcc_back.sv
`include "dcc_packet_bit_transmitter_defines.svh"

module dcc_back import dcc_pkg::*; #(
  parameter int MAX_PACKET_BYTES = DEF_MAX_PACKET_BYTES,
  parameter int TICK_COUNT_BITS  = DEF_TICK_COUNT_BITS
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  input  dcc_cmd_t  q_cmd,
  output logic      q_pop,
  dcc_cfg_if.sink   cfg_ch,
  dcc_out_if.source out_ch
);

  localparam int IW = $clog2(MAX_PACKET_BYTES);
  localparam int PW = $clog2(MAX_PACKET_BYTES + 1);
  localparam int CW = ((TICK_COUNT_BITS > HALF_W) ? TICK_COUNT_BITS : HALF_W) + 1;

  localparam logic [2:0] PH_PREAMBLE = 3'd0;
  localparam logic [2:0] PH_START    = 3'd1;
  localparam logic [2:0] PH_DATA     = 3'd2;
  localparam logic [2:0] PH_SEP      = 3'd3;
  localparam logic [2:0] PH_END      = 3'd4;

  logic [PRE_W-1:0]  preamble_bits_r;
  logic [HALF_W-1:0] one_half_r;
  logic [HALF_W-1:0] zero_half_r;

  logic [BYTE_W-1:0] act_bytes_r  [MAX_PACKET_BYTES];
  logic [BYTE_W-1:0] pend_bytes_r [MAX_PACKET_BYTES];
  logic [PW-1:0]     act_count_r, act_count_nxt;
  logic [PW-1:0]     pend_count_r, pend_count_nxt;
  logic              swap_armed_r, swap_armed_nxt;

  logic [2:0]                 phase_r, phase_nxt;
  logic [PRE_W-1:0]           pre_cnt_r, pre_cnt_nxt;
  logic [PW-1:0]              byte_ptr_r, byte_ptr_nxt;
  logic [2:0]                 bit_ptr_r, bit_ptr_nxt;
  logic                       second_half_r, second_half_nxt;
  logic [TICK_COUNT_BITS-1:0] tick_cnt_r, tick_cnt_nxt;

  logic out_valid_r, out_valid_nxt;
  logic out_line_r;
  logic out_bit_start_r;
  logic out_pkt_start_r;

  logic              slot_free;
  logic              do_tick;
  logic              do_load;
  logic              cur_bit;
  logic [HALF_W-1:0] half_sel;
  logic [CW-1:0]     half_eff;
  logic [CW-1:0]     span;
  logic [CW-1:0]     tick_inc;
  logic              half_done;
  logic              bit_done;
  logic              swap_do;
  logic [PW-1:0]     count_eff;
  logic [PW-1:0]     byte_inc;
  logic              first_tick;
  logic [PW-1:0]     load_count;

  assign slot_free = !out_valid_r || out_ch.ready;
  assign q_pop     = q_valid && (q_cmd.is_load || slot_free);
  assign do_tick   = q_pop && !q_cmd.is_load;
  assign do_load   = q_pop && q_cmd.is_load;

  assign count_eff = (act_count_r == '0) ? PW'(1) : act_count_r;
  assign byte_inc  = byte_ptr_r + PW'(1);

  always_comb begin
    cur_bit = 1'b1;
    case (phase_r)
      PH_START, PH_SEP: begin
        cur_bit = 1'b0;
      end
      PH_DATA: begin
        if (32'(byte_ptr_r) < MAX_PACKET_BYTES) begin
          cur_bit = act_bytes_r[byte_ptr_r[IW-1:0]][bit_ptr_r];
        end else begin
          cur_bit = 1'b0;
        end
      end
      default: begin
        cur_bit = 1'b1;
      end
    endcase
  end

  always_comb begin
    half_sel = cur_bit ? one_half_r : zero_half_r;
    span     = CW'(1) << TICK_COUNT_BITS;
    half_eff = (half_sel == '0) ? CW'(1) : CW'(half_sel);
    if (half_eff > span) begin
      half_eff = span;
    end
    tick_inc  = CW'(tick_cnt_r) + CW'(1);
    half_done = (tick_inc >= half_eff);
  end

  assign bit_done   = do_tick && half_done && second_half_r;
  assign swap_do    = bit_done && (phase_r == PH_START) && swap_armed_r;
  assign first_tick = !second_half_r && (tick_cnt_r == '0);
  assign load_count = (32'(q_cmd.byte_count) > MAX_PACKET_BYTES) ?
                      PW'(MAX_PACKET_BYTES) : PW'(q_cmd.byte_count);

  always_comb begin
    phase_nxt       = phase_r;
    pre_cnt_nxt     = pre_cnt_r;
    byte_ptr_nxt    = byte_ptr_r;
    bit_ptr_nxt     = bit_ptr_r;
    second_half_nxt = second_half_r;
    tick_cnt_nxt    = tick_cnt_r;
    if (do_tick) begin
      if (half_done) begin
        tick_cnt_nxt    = '0;
        second_half_nxt = !second_half_r;
        if (second_half_r) begin
          case (phase_r)
            PH_PREAMBLE: begin
              pre_cnt_nxt = pre_cnt_r + PRE_W'(1);
              if (pre_cnt_nxt == '0 || pre_cnt_nxt >= preamble_bits_r) begin
                phase_nxt = PH_START;
              end
            end
            PH_START: begin
              phase_nxt    = PH_DATA;
              byte_ptr_nxt = '0;
              bit_ptr_nxt  = 3'd7;
            end
            PH_DATA: begin
              if (bit_ptr_r == 3'd0) begin
                byte_ptr_nxt = byte_inc;
                phase_nxt    = (byte_inc >= count_eff) ? PH_END : PH_SEP;
              end else begin
                bit_ptr_nxt = bit_ptr_r - 3'd1;
              end
            end
            PH_SEP: begin
              phase_nxt   = PH_DATA;
              bit_ptr_nxt = 3'd7;
            end
            default: begin
              phase_nxt    = PH_PREAMBLE;
              pre_cnt_nxt  = '0;
              byte_ptr_nxt = '0;
              bit_ptr_nxt  = 3'd7;
            end
          endcase
        end
      end else begin
        tick_cnt_nxt = tick_inc[TICK_COUNT_BITS-1:0];
      end
    end
  end

  always_comb begin
    swap_armed_nxt = swap_armed_r;
    pend_count_nxt = pend_count_r;
    act_count_nxt  = act_count_r;
    if (do_load && q_cmd.packet_done) begin
      swap_armed_nxt = 1'b1;
      pend_count_nxt = load_count;
    end else if (swap_do) begin
      swap_armed_nxt = 1'b0;
      act_count_nxt  = pend_count_r;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (do_tick) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      preamble_bits_r <= RST_PREAMBLE_BITS;
      one_half_r      <= RST_ONE_HALF_TICKS;
      zero_half_r     <= RST_ZERO_HALF_TICKS;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_PREAMBLE_BITS: begin
          preamble_bits_r <= cfg_ch.data[PRE_W-1:0];
        end
        CFG_ONE_HALF_TICKS: begin
          one_half_r <= cfg_ch.data[HALF_W-1:0];
        end
        CFG_ZERO_HALF_TICKS: begin
          zero_half_r <= cfg_ch.data[HALF_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_PREAMBLE;
      pre_cnt_r     <= '0;
      byte_ptr_r    <= '0;
      bit_ptr_r     <= 3'd7;
      second_half_r <= 1'b0;
      tick_cnt_r    <= '0;
      act_count_r   <= PW'(IDLE_COUNT);
      pend_count_r  <= '0;
      swap_armed_r  <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      phase_r       <= phase_nxt;
      pre_cnt_r     <= pre_cnt_nxt;
      byte_ptr_r    <= byte_ptr_nxt;
      bit_ptr_r     <= bit_ptr_nxt;
      second_half_r <= second_half_nxt;
      tick_cnt_r    <= tick_cnt_nxt;
      act_count_r   <= act_count_nxt;
      pend_count_r  <= pend_count_nxt;
      swap_armed_r  <= swap_armed_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_PACKET_BYTES; i++) begin
        act_bytes_r[i] <= (i == 0 || i == 2) ? IDLE_FILL_BYTE : '0;
      end
    end else if (swap_do) begin
      for (int i = 0; i < MAX_PACKET_BYTES; i++) begin
        act_bytes_r[i] <= pend_bytes_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_load && q_cmd.idx_ok) begin
      pend_bytes_r[IW'(q_cmd.byte_index)] <= q_cmd.byte_value;
    end
  end

  always_ff @(posedge clk) begin
    if (do_tick) begin
      out_line_r      <= !second_half_r;
      out_bit_start_r <= first_tick;
      out_pkt_start_r <= first_tick && (phase_r == PH_PREAMBLE) && (pre_cnt_r == '0);
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.line_level   = out_line_r;
  assign out_ch.bit_start    = out_bit_start_r;
  assign out_ch.packet_start = out_pkt_start_r;

  `DCC_ASSERT_NEXT(a_load_makes_no_word, clk, rst_n, do_load && !out_valid_r, !out_valid_r, "A load word produced a result.")
  `DCC_ASSERT_NEXT(a_swap_takes_pending, clk, rst_n, swap_do, !swap_armed_r && act_count_r == $past(pend_count_r), "Packet swap did not complete.")
  `DCC_ASSERT_NOW(a_ptr_in_packet, clk, rst_n, phase_r == PH_DATA, byte_ptr_r < count_eff, "Byte pointer ran past the packet.")

endmodule

### rtl/dcc_packet_bit_transmitter.sv
// Repeats a DCC track packet on one line: a preamble of one-bits, a zero start bit, each
// byte MSB first with zero separators, and a one end bit. Each tick word yields one result
// word carrying the line level for that tick, and each load word fills the pending packet
// and yields nothing. The block takes one word per clock while its queue has room; each
// word reaches the packet engine through a four-entry queue; results leave a register.
// The engine retires one queued word per cycle, a tick word only while that register is
// free. Write configuration only while the block is idle; the block does not enforce it.
module dcc_packet_bit_transmitter import dcc_pkg::*; #(
  parameter int MAX_PACKET_BYTES = DEF_MAX_PACKET_BYTES,
  parameter int TICK_COUNT_BITS  = DEF_TICK_COUNT_BITS
) (
  input  logic      clk,
  input  logic      rst_n,
  dcc_in_if.sink    in_ch,
  dcc_out_if.source out_ch,
  dcc_cfg_if.sink   cfg_ch
);

  logic     q_valid;
  dcc_cmd_t q_cmd;
  logic     q_pop;

  dcc_front #(
    .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_valid (q_valid),
    .q_cmd   (q_cmd),
    .q_pop   (q_pop)
  );

  dcc_back #(
    .MAX_PACKET_BYTES(MAX_PACKET_BYTES),
    .TICK_COUNT_BITS (TICK_COUNT_BITS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_cmd   (q_cmd),
    .q_pop   (q_pop),
    .cfg_ch  (cfg_ch),
    .out_ch  (out_ch)
  );

endmodule

### bench/dcc_packet_bit_transmitter_tb.sv
`timescale 1ns / 1ps

module dcc_packet_bit_transmitter_tb;
  import dcc_pkg::*;

  localparam int MAX_BYTES = DEF_MAX_PACKET_BYTES;
  localparam logic FUNC_TICK = 1'b0;
  localparam logic FUNC_LOAD = 1'b1;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES = 16;

  typedef enum logic [2:0] {
    FR_PREAMBLE,
    FR_START,
    FR_DATA,
    FR_SEP,
    FR_END
  } frame_t;

  typedef struct packed {
    logic               func;
    logic [BYTE_W-1:0]  byte_value;
    logic [INDEX_W-1:0] byte_index;
    logic               packet_done;
    logic [COUNT_W-1:0] byte_count;
  } track_word_t;

  typedef struct packed {
    logic level;
    logic bit_first;
    logic pkt_first;
  } line_sample_t;

  logic clk;
  logic rst_n;

  dcc_in_if  in_bus ();
  dcc_out_if out_bus ();
  dcc_cfg_if cfg_bus ();

  dcc_packet_bit_transmitter u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus),
    .cfg_ch (cfg_bus)
  );

  track_word_t  track_words[$];
  line_sample_t line_samples_q[$];
  track_word_t  held_word;
  int unsigned  queued_words;
  int unsigned  accepted_words;
  int unsigned  mismatch_count;
  bit           steady;

  logic [PRE_W-1:0]  cfg_pre_len;
  logic [HALF_W-1:0] cfg_one_half;
  logic [HALF_W-1:0] cfg_zero_half;

  logic [BYTE_W-1:0]  tx_bytes [MAX_BYTES];
  logic [BYTE_W-1:0]  staged_bytes [MAX_BYTES];
  int unsigned        tx_count;
  int unsigned        staged_count;
  bit                 swap_armed;
  frame_t             frame;
  logic [PRE_W-1:0]   pre_cnt;
  int unsigned        byte_ptr;
  logic [2:0]         bit_ptr;
  bit                 low_half;
  int unsigned        half_cnt;

  always #6 clk = ~clk;

  function automatic void reset_track();
    cfg_pre_len   = RST_PREAMBLE_BITS;
    cfg_one_half  = RST_ONE_HALF_TICKS;
    cfg_zero_half = RST_ZERO_HALF_TICKS;
    foreach (tx_bytes[i]) begin
      tx_bytes[i] = '0;
      staged_bytes[i] = '0;
    end
    tx_bytes[0]  = IDLE_FILL_BYTE;
    tx_bytes[2]  = IDLE_FILL_BYTE;
    tx_count     = IDLE_COUNT;
    staged_count = 0;
    swap_armed   = 1'b0;
    frame        = FR_PREAMBLE;
    pre_cnt      = '0;
    byte_ptr     = 0;
    bit_ptr      = 3'd7;
    low_half     = 1'b0;
    half_cnt     = 0;
  endfunction

  // Each tick word yields its line sample and then moves the bit timer; a load word stages its byte.
  function automatic void advance_track(input track_word_t w);
    logic         cur_bit;
    logic         first;
    int unsigned  half;
    int unsigned  n;
    line_sample_t s;
    if (w.func == FUNC_LOAD) begin
      staged_bytes[w.byte_index] = w.byte_value;
      if (w.packet_done) begin
        staged_count = (w.byte_count > MAX_BYTES) ? MAX_BYTES : w.byte_count;
        swap_armed = 1'b1;
      end
      return;
    end
    case (frame)
      FR_START, FR_SEP: cur_bit = 1'b0;
      FR_DATA: cur_bit = tx_bytes[byte_ptr][bit_ptr];
      default: cur_bit = 1'b1;
    endcase
    first = !low_half && half_cnt == 0;
    s.level = !low_half;
    s.bit_first = first;
    s.pkt_first = first && frame == FR_PREAMBLE && pre_cnt == 0;
    line_samples_q.push_back(s);
    half = cur_bit ? cfg_one_half : cfg_zero_half;
    if (half == 0) half = 1;
    half_cnt++;
    if (half_cnt >= half) begin
      half_cnt = 0;
      if (!low_half) begin
        low_half = 1'b1;
      end else begin
        low_half = 1'b0;
        n = (tx_count == 0) ? 1 : tx_count;
        case (frame)
          FR_PREAMBLE: begin
            pre_cnt = pre_cnt + 1'b1;
            if (pre_cnt == 0 || pre_cnt >= cfg_pre_len) frame = FR_START;
          end
          FR_START: begin
            if (swap_armed) begin
              tx_bytes = staged_bytes;
              tx_count = staged_count;
              swap_armed = 1'b0;
            end
            frame = FR_DATA;
            byte_ptr = 0;
            bit_ptr = 3'd7;
          end
          FR_DATA: begin
            if (bit_ptr == 0) begin
              byte_ptr++;
              frame = (byte_ptr >= n) ? FR_END : FR_SEP;
            end else begin
              bit_ptr--;
            end
          end
          FR_SEP: begin
            frame = FR_DATA;
            bit_ptr = 3'd7;
          end
          default: begin
            frame = FR_PREAMBLE;
            pre_cnt = '0;
            byte_ptr = 0;
            bit_ptr = 3'd7;
          end
        endcase
      end
    end
  endfunction

  function automatic track_word_t make_word(input logic func);
    track_word_t w;
    w.func        = func;
    w.byte_value  = BYTE_W'($urandom);
    w.byte_index  = INDEX_W'($urandom);
    w.packet_done = 1'($urandom);
    w.byte_count  = COUNT_W'($urandom);
    return w;
  endfunction

  task automatic queue_word(input track_word_t w);
    track_words.push_back(w);
    queued_words++;
  endtask

  task automatic check_bit(input string what, input logic want, input logic got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0b, got %0b", $time, what, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        advance_track(held_word);
        accepted_words++;
      end
      if (!in_bus.valid || in_bus.ready) begin
        if (track_words.size() > 0 && (steady || $urandom_range(0, 99) >= 12)) begin
          held_word = track_words.pop_front();
          in_bus.valid       <= 1'b1;
          in_bus.func        <= held_word.func;
          in_bus.byte_value  <= held_word.byte_value;
          in_bus.byte_index  <= held_word.byte_index;
          in_bus.packet_done <= held_word.packet_done;
          in_bus.byte_count  <= held_word.byte_count;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    line_sample_t want;
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= steady || $urandom_range(0, 99) >= 12;
      if (out_bus.valid && out_bus.ready) begin
        if (line_samples_q.size() == 0) begin
          $display("%0t ns: unexpected line sample, expected none, got %0b%0b%0b", $time,
                   out_bus.line_level, out_bus.bit_start, out_bus.packet_start);
          mismatch_count++;
        end else begin
          want = line_samples_q.pop_front();
          check_bit("line_level", want.level, out_bus.line_level);
          check_bit("bit_start", want.bit_first, out_bus.bit_start);
          check_bit("packet_start", want.pkt_first, out_bus.packet_start);
        end
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    do @(posedge clk); while (!cfg_bus.ready);
    case (idx)
      CFG_PREAMBLE_BITS: cfg_pre_len = val[PRE_W-1:0];
      CFG_ONE_HALF_TICKS: cfg_one_half = val;
      CFG_ZERO_HALF_TICKS: cfg_zero_half = val;
      default: ;
    endcase
    cfg_bus.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_timing(input logic [CFG_DATA_W-1:0] pre, input logic [CFG_DATA_W-1:0] one,
                            input logic [CFG_DATA_W-1:0] zero);
    write_reg(CFG_PREAMBLE_BITS, pre);
    write_reg(CFG_ONE_HALF_TICKS, one);
    write_reg(CFG_ZERO_HALF_TICKS, zero);
  endtask

  // Load words can still sit inside the block after the last line sample, so the
  // wait also lets the queue drain before the caller touches the registers.
  task automatic settle();
    @(posedge clk);
    while (accepted_words != queued_words || line_samples_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic random_traffic(input int budget);
    int          made;
    int          sel;
    int          c;
    track_word_t w;
    made = 0;
    while (made < budget) begin
      sel = $urandom_range(0, 99);
      if (sel < 70) begin
        repeat ($urandom_range(1, 20)) begin
          queue_word(make_word(FUNC_TICK));
          made++;
        end
      end else if (sel < 90) begin
        c = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : $urandom_range(1, 3);
        for (int i = 0; i < c; i++) begin
          w = make_word(FUNC_LOAD);
          w.byte_index = INDEX_W'(i);
          w.packet_done = (i == c - 1);
          if (i == c - 1) begin
            w.byte_count = COUNT_W'((c == MAX_BYTES && $urandom_range(0, 1)) ?
                                    $urandom_range(8, 15) : c);
          end
          queue_word(w);
          made++;
        end
      end else begin
        queue_word(make_word(FUNC_LOAD));
        made++;
      end
    end
  endtask

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    logic [BYTE_W-1:0] fill [MAX_BYTES];
    track_word_t       w;
    clk = 1'b0;
    rst_n = 1'b0;
    steady = 1'b0;
    queued_words = 0;
    accepted_words = 0;
    mismatch_count = 0;
    in_bus.valid = 1'b0;
    in_bus.func = FUNC_TICK;
    in_bus.byte_value = '0;
    in_bus.byte_index = '0;
    in_bus.packet_done = 1'b0;
    in_bus.byte_count = '0;
    out_bus.ready = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = CFG_PREAMBLE_BITS;
    cfg_bus.data = '0;
    reset_track();
    fill = '{8'h00, 8'hFF, 8'hA5, 8'h5A, 8'h80, 8'h01, 8'h7F, 8'hFE};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Every pending byte is written here first, so a later swap never copies an
    // entry that holds no data.
    repeat (3) queue_word(make_word(FUNC_TICK));
    for (int i = 0; i < MAX_BYTES; i++) begin
      w = make_word(FUNC_LOAD);
      w.byte_index = INDEX_W'(i);
      w.byte_value = fill[i];
      w.packet_done = 1'b0;
      queue_word(w);
    end
    w = make_word(FUNC_LOAD);
    w.byte_index = 3'd7;
    w.byte_value = 8'h81;
    w.packet_done = 1'b1;
    w.byte_count = 4'd15;
    queue_word(w);
    w.byte_index = 3'd0;
    w.byte_value = 8'hC3;
    w.byte_count = 4'd0;
    queue_word(w);
    repeat (8) queue_word(make_word(FUNC_TICK));

    settle();
    write_reg(CFG_UNUSED, CFG_DATA_W'($urandom));
    set_timing(16'd0, 16'd0, 16'd0);
    random_traffic(150);

    settle();
    set_timing(16'd31, 16'd1, 16'd2);
    steady = 1'b1;
    random_traffic(200);

    settle();
    steady = 1'b0;
    set_timing(16'd1, 16'hFFFF, 16'hFFFF);
    random_traffic(60);

    settle();
    set_timing(16'hFFE3, 16'd2, 16'd1);
    random_traffic(150);

    for (int p = 0; p < 5; p++) begin
      settle();
      set_timing(CFG_DATA_W'($urandom_range(1, 6)), CFG_DATA_W'($urandom_range(0, 4)),
                 CFG_DATA_W'($urandom_range(0, 4)));
      random_traffic(150);
    end

    settle();
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/dcc_pkg.sv
rtl/dcc_in_if.sv
rtl/dcc_out_if.sv
rtl/dcc_cfg_if.sv
rtl/dcc_front.sv
rtl/dcc_back.sv
rtl/dcc_packet_bit_transmitter.sv
bench/dcc_packet_bit_transmitter_tb.sv
